[hw/rtl/cwfs_pkg.sv]
// Types, constants and status codes shared by the clip window frame selector.
`default_nettype none

package cwfs_pkg;

  localparam int unsigned MAX_FRAMES = 1024;
  localparam int unsigned CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PICK_W     = $clog2(MAX_FRAMES);

  localparam int unsigned TIME_W     = 64;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned BEGIN_W    = 10;
  localparam int unsigned END_W      = 11;
  localparam int unsigned NEAR_W     = 10;
  localparam int unsigned CFG_IDX_W  = 8;

  typedef logic        [TIME_W-1:0] word_t;
  typedef logic signed [TIME_W-1:0] stime_t;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 4'd0,
    ST_BAD_WINDOW   = 4'd1,
    ST_NO_MAPPER    = 4'd2,
    ST_NO_FRAMES    = 4'd3,
    ST_ID_NOT_INC   = 4'd4,
    ST_ID_GAP       = 4'd5,
    ST_DEV_NOT_INC  = 4'd6,
    ST_UNMAPPABLE   = 4'd7,
    ST_HOST_NOT_INC = 4'd8,
    ST_PRE_SHORT    = 4'd9,
    ST_POST_SHORT   = 4'd10,
    ST_BOTH_SHORT   = 4'd11,
    ST_TOO_MANY     = 4'd12
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIKE       = 8'd0,
    CFG_PRE_ROLL     = 8'd1,
    CFG_POST_ROLL    = 8'd2,
    CFG_MAPPER_READY = 8'd3
  } cfg_idx_e;

  // One frame record as held in the input stage
  typedef struct packed {
    word_t  seq_num;
    word_t  dev_time;
    stime_t mapped_time;
    logic   mapped_valid;
  } frame_t;

  // Window settings seen by the tracker
  typedef struct packed {
    stime_t strike;
    stime_t req_start;
    stime_t req_end;
  } win_cfg_t;

  typedef struct packed {
    logic take;   // frame record present this cycle
    logic clear;  // end request retired this cycle
  } track_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]  frame_count;
    stime_t            prev_host;
    stime_t            first_host;
    status_e           order_error;
    status_e           mapping_error;
    logic [PICK_W-1:0] start_pick;
    stime_t            start_pick_time;
    logic [PICK_W-1:0] end_pick;
    stime_t            end_pick_time;
    logic              end_found;
    logic [PICK_W-1:0] near_pick;
    stime_t            near_pick_time;
    logic              near_found;
    logic              overflowed;
  } track_t;

endpackage

`default_nettype wire

[hw/rtl/cwfs_if.sv]
// Valid/ready channel interfaces: frame input, window result and register writes.
`default_nettype none

interface cwfs_in_if;
  import cwfs_pkg::*;
  logic   valid;
  logic   ready;
  logic   kind;
  word_t  seq_num;
  word_t  dev_time;
  stime_t mapped_time;
  logic   mapped_valid;

  modport source (output valid, kind, seq_num, dev_time, mapped_time, mapped_valid,
                  input ready);
  modport sink   (input valid, kind, seq_num, dev_time, mapped_time, mapped_valid,
                  output ready);
endinterface

interface cwfs_out_if;
  import cwfs_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BEGIN_W-1:0]  start_index;
  logic [END_W-1:0]    stop_index;
  logic [NEAR_W-1:0]   strike_index;
  stime_t              strike_frame_time;
  stime_t              strike_time_error;
  stime_t              want_start_time;
  stime_t              want_stop_time;
  stime_t              selected_start_time;
  stime_t              chosen_stop_time;
  stime_t              lead_time;
  stime_t              trail_time;

  modport source (output valid, status, start_index, stop_index, strike_index,
                  strike_frame_time, strike_time_error, want_start_time,
                  want_stop_time, selected_start_time, chosen_stop_time,
                  lead_time, trail_time,
                  input ready);
  modport sink   (input valid, status, start_index, stop_index, strike_index,
                  strike_frame_time, strike_time_error, want_start_time,
                  want_stop_time, selected_start_time, chosen_stop_time,
                  lead_time, trail_time,
                  output ready);
endinterface

interface cwfs_cfg_if;
  import cwfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/cwfs_track.sv]
// Per-frame ordering checks and start/end/nearest frame tracking.
`default_nettype none

module cwfs_track (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cwfs_pkg::track_ctrl_t ctrl_i,
  input  cwfs_pkg::frame_t      frame_i,
  input  cwfs_pkg::win_cfg_t    cfg_i,
  output cwfs_pkg::track_t      state_o
);
  import cwfs_pkg::*;

  track_t state_q, state_d;
  word_t  prev_id_q, prev_dev_q;

  logic              full, first;
  logic [PICK_W-1:0] idx;
  stime_t            t;
  word_t             dist_lo, dist_hi;

  assign full   = state_q.frame_count >= CNT_W'(MAX_FRAMES);
  assign first  = state_q.frame_count == '0;
  assign idx    = state_q.frame_count[PICK_W-1:0];
  assign t      = frame_i.mapped_time;
  // exact unsigned distances on either side of the strike
  assign dist_lo = word_t'(cfg_i.strike) - word_t'(state_q.prev_host);
  assign dist_hi = word_t'(t) - word_t'(cfg_i.strike);

  always_comb begin
    state_d = state_q;
    if (ctrl_i.clear) begin
      state_d = '0;
    end else if (ctrl_i.take) begin
      if (full) begin
        state_d.overflowed = 1'b1;
      end else begin
        if (!first && state_q.order_error == ST_OK) begin
          if (frame_i.seq_num <= prev_id_q) begin
            state_d.order_error = ST_ID_NOT_INC;
          end else if (frame_i.seq_num != prev_id_q + word_t'(1)) begin
            state_d.order_error = ST_ID_GAP;
          end else if (frame_i.dev_time <= prev_dev_q) begin
            state_d.order_error = ST_DEV_NOT_INC;
          end
        end
        if (state_q.mapping_error == ST_OK) begin
          if (!frame_i.mapped_valid) begin
            state_d.mapping_error = ST_UNMAPPABLE;
          end else if (!first && $signed(t) <= $signed(state_q.prev_host)) begin
            state_d.mapping_error = ST_HOST_NOT_INC;
          end
        end
        if (first) begin
          state_d.first_host = t;
        end
        if ($signed(t) <= $signed(cfg_i.req_start)) begin
          state_d.start_pick      = idx;
          state_d.start_pick_time = t;
        end
        if (!state_q.end_found && $signed(cfg_i.req_end) <= $signed(t)) begin
          state_d.end_pick      = idx;
          state_d.end_pick_time = t;
          state_d.end_found     = 1'b1;
        end
        if (!state_q.near_found && $signed(cfg_i.strike) <= $signed(t)) begin
          state_d.near_found = 1'b1;
          // tie goes to the earlier frame
          if (!first && dist_lo <= dist_hi) begin
            state_d.near_pick      = idx - PICK_W'(1);
            state_d.near_pick_time = state_q.prev_host;
          end else begin
            state_d.near_pick      = idx;
            state_d.near_pick_time = t;
          end
        end
        state_d.prev_host   = t;
        state_d.frame_count = state_q.frame_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // only read once a frame of the current list has written them
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && !full) begin
      prev_id_q  <= frame_i.seq_num;
      prev_dev_q <= frame_i.dev_time;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

[hw/rtl/clip_window_frame_selector.sv]
// Top level: clip window frame selector with register port, input stage and result register.
//
//   channel  dir  role     payload
//   cfg_i    in   sink     index, data (register writes, always ready)
//   in_i     in   sink     kind, seq_num, dev_time, mapped_time, mapped_valid
//   out_o    out  source   status and window fields, one per end request
//
// One request per cycle: a request is registered in the input stage, then worked by the
// tracker (frame) or the status logic (end), whose result lands in the output register.
// A waiting result stalls only an end request in the input stage; frame requests keep flowing.
// Reset clears the registers, the list state and both channel stages.
`default_nettype none

module clip_window_frame_selector (
  input  logic       clk_i,
  input  logic       rst_ni,
  cwfs_cfg_if.sink   cfg_i,
  cwfs_in_if.sink    in_i,
  cwfs_out_if.source out_o
);
  import cwfs_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [BEGIN_W-1:0] start_index;
    logic [END_W-1:0]   stop_index;
    logic [NEAR_W-1:0]  strike_index;
    stime_t             strike_frame_time;
    stime_t             strike_time_error;
    stime_t             want_start_time;
    stime_t             want_stop_time;
    stime_t             selected_start_time;
    stime_t             chosen_stop_time;
    stime_t             lead_time;
    stime_t             trail_time;
  } res_t;

  // registers
  stime_t strike_q, strike_d, pre_q, pre_d, post_q, post_d;
  stime_t req_start_q, req_start_d, req_end_q, req_end_d;
  logic   mapper_ready_q, mapper_ready_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    strike_d       = strike_q;
    pre_d          = pre_q;
    post_d         = post_q;
    req_start_d    = req_start_q;
    req_end_d      = req_end_q;
    mapper_ready_d = mapper_ready_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_STRIKE: begin
          strike_d    = cfg_i.data;
          req_start_d = cfg_i.data - pre_q;
          req_end_d   = cfg_i.data + post_q;
        end
        CFG_PRE_ROLL: begin
          pre_d       = cfg_i.data;
          req_start_d = strike_q - cfg_i.data;
        end
        CFG_POST_ROLL: begin
          post_d    = cfg_i.data;
          req_end_d = strike_q + cfg_i.data;
        end
        CFG_MAPPER_READY: mapper_ready_d = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strike_q       <= '0;
      pre_q          <= '0;
      post_q         <= '0;
      req_start_q    <= '0;
      req_end_q      <= '0;
      mapper_ready_q <= 1'b0;
    end else begin
      strike_q       <= strike_d;
      pre_q          <= pre_d;
      post_q         <= post_d;
      req_start_q    <= req_start_d;
      req_end_q      <= req_end_d;
      mapper_ready_q <= mapper_ready_d;
    end
  end

  // input stage
  logic   s1_valid_q, s1_kind_q, s1_adv, in_fire;
  frame_t s1_frame_q;
  logic   out_valid_q;
  res_t   res_q, res_d;

  assign s1_adv     = s1_valid_q && (s1_kind_q != KIND_END || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q               <= in_i.kind;
      s1_frame_q.seq_num      <= in_i.seq_num;
      s1_frame_q.dev_time     <= in_i.dev_time;
      s1_frame_q.mapped_time  <= in_i.mapped_time;
      s1_frame_q.mapped_valid <= in_i.mapped_valid;
    end
  end

  // frame tracking
  track_ctrl_t ctrl;
  win_cfg_t    win;
  track_t      st;

  assign ctrl.take     = s1_valid_q && s1_kind_q != KIND_END;
  assign ctrl.clear    = s1_valid_q && s1_kind_q == KIND_END && s1_adv;
  assign win.strike    = strike_q;
  assign win.req_start = req_start_q;
  assign win.req_end   = req_end_q;

  cwfs_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .frame_i (s1_frame_q),
    .cfg_i   (win),
    .state_o (st)
  );

  // end-of-list status and window
  status_e           status;
  logic              miss_pre, miss_post;
  logic [PICK_W-1:0] near_i;
  stime_t            near_t;

  assign miss_pre  = $signed(req_start_q) < $signed(st.first_host);
  assign miss_post = $signed(st.prev_host) < $signed(req_end_q);
  assign near_i    = st.near_found ? st.near_pick
                                   : PICK_W'(st.frame_count - CNT_W'(1));
  assign near_t    = st.near_found ? st.near_pick_time : st.prev_host;

  always_comb begin
    if (pre_q[TIME_W-1] || post_q[TIME_W-1]) begin
      status = ST_BAD_WINDOW;
    end else if (!mapper_ready_q) begin
      status = ST_NO_MAPPER;
    end else if (st.frame_count == '0) begin
      status = ST_NO_FRAMES;
    end else if (st.overflowed) begin
      status = ST_TOO_MANY;
    end else if (st.order_error != ST_OK) begin
      status = st.order_error;
    end else if (st.mapping_error != ST_OK) begin
      status = st.mapping_error;
    end else if (miss_pre && miss_post) begin
      status = ST_BOTH_SHORT;
    end else if (miss_pre) begin
      status = ST_PRE_SHORT;
    end else if (miss_post) begin
      status = ST_POST_SHORT;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = status;
    if (status == ST_OK) begin
      res_d.start_index         = BEGIN_W'(st.start_pick);
      res_d.stop_index          = END_W'({1'b0, st.end_pick} + (PICK_W + 1)'(1));
      res_d.strike_index        = NEAR_W'(near_i);
      res_d.strike_frame_time   = near_t;
      res_d.strike_time_error   = near_t - strike_q;
      res_d.want_start_time     = req_start_q;
      res_d.want_stop_time      = req_end_q;
      res_d.selected_start_time = st.start_pick_time;
      res_d.chosen_stop_time    = st.end_pick_time;
      res_d.lead_time           = strike_q - st.start_pick_time;
      res_d.trail_time          = st.end_pick_time - strike_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.status              = res_q.status;
  assign out_o.start_index         = res_q.start_index;
  assign out_o.stop_index          = res_q.stop_index;
  assign out_o.strike_index        = res_q.strike_index;
  assign out_o.strike_frame_time   = res_q.strike_frame_time;
  assign out_o.strike_time_error   = res_q.strike_time_error;
  assign out_o.want_start_time     = res_q.want_start_time;
  assign out_o.want_stop_time      = res_q.want_stop_time;
  assign out_o.selected_start_time = res_q.selected_start_time;
  assign out_o.chosen_stop_time    = res_q.chosen_stop_time;
  assign out_o.lead_time           = res_q.lead_time;
  assign out_o.trail_time          = res_q.trail_time;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for the clip window frame selector: directed list table, capacity lists, then random frame lists.
`timescale 1ns / 100ps

module tb_top;
  import cwfs_pkg::*;

  localparam int    QUIET_LIMIT = 1000;
  localparam word_t SIGN_BIT    = 64'h8000_0000_0000_0000;
  localparam word_t TIME_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam word_t ALL_ONES    = '1;

  typedef enum {ROW_CFG, ROW_FRAME, ROW_END} row_op_e;
  typedef enum {FLT_ID_BACK, FLT_ID_GAP, FLT_DEV_BACK, FLT_UNMAPPED, FLT_HOST_BACK} fault_e;

  typedef struct {
    row_op_e op;
    word_t   a, b, c;  // cfg: strike, pre, post; frame: id, device time, host time
    logic    flag;     // cfg: mapper ready; frame: mapped valid
    bit      typed;    // end: status given here, every other field zero
    status_e want;
  } row_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [END_W-1:0]    idx [3];
    word_t               tm [8];
  } window_t;

  // running state of the frame list being collected
  typedef struct {
    int unsigned count;
    word_t       last_id, last_dev, last_host, first_host;
    status_e     seq_fault, map_fault;
    int unsigned lo_idx, hi_idx, mid_idx;
    word_t       lo_time, hi_time, mid_time;
    bit          hi_seen, mid_seen, spilled;
  } list_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cwfs_cfg_if cfg_ch ();
  cwfs_in_if  in_ch ();
  cwfs_out_if out_ch ();

  clip_window_frame_selector uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  word_t   strike_w, pre_w, post_w;
  logic    mapper_on;
  list_t   trk;
  window_t pending_windows [$];
  int      fails = 0;
  int      quiet = 0;
  bit      no_idle = 1'b0;
  int      rand_sent = 0;

  string idx_name [3] = '{"start_index", "stop_index", "strike_index"};
  string tm_name [8] = '{"strike_frame_time", "strike_time_error", "want_start_time",
                         "want_stop_time", "selected_start_time", "chosen_stop_time",
                         "lead_time", "trail_time"};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t pick_roll();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return rand64() | SIGN_BIT;
    if (r < 10) return TIME_MAX;
    if (r < 15) return '0;
    return word_t'($urandom_range(0, 3000));
  endfunction

  function automatic void clear_list();
    trk.count      = 0;
    trk.last_id    = '0;
    trk.last_dev   = '0;
    trk.last_host  = '0;
    trk.first_host = '0;
    trk.seq_fault  = ST_OK;
    trk.map_fault  = ST_OK;
    trk.lo_idx     = 0;
    trk.hi_idx     = 0;
    trk.mid_idx    = 0;
    trk.lo_time    = '0;
    trk.hi_time    = '0;
    trk.mid_time   = '0;
    trk.hi_seen    = 1'b0;
    trk.mid_seen   = 1'b0;
    trk.spilled    = 1'b0;
  endfunction

  function automatic window_t blank_window(status_e s);
    window_t w;
    w.status = s;
    foreach (w.idx[i]) w.idx[i] = '0;
    foreach (w.tm[i]) w.tm[i] = '0;
    return w;
  endfunction

  function automatic void log_frame(word_t id, word_t dev, word_t t, logic ok);
    word_t       win_lo, win_hi, dist_lo, dist_hi;
    int unsigned n;
    win_lo = strike_w - pre_w;
    win_hi = strike_w + post_w;
    n = trk.count;
    // past capacity: dropped unchecked
    if (n >= MAX_FRAMES) begin
      trk.spilled = 1'b1;
      return;
    end
    if (n > 0 && trk.seq_fault == ST_OK) begin
      if (id <= trk.last_id) trk.seq_fault = ST_ID_NOT_INC;
      else if (id - trk.last_id != 64'd1) trk.seq_fault = ST_ID_GAP;
      else if (dev <= trk.last_dev) trk.seq_fault = ST_DEV_NOT_INC;
    end
    if (trk.map_fault == ST_OK) begin
      if (!ok) trk.map_fault = ST_UNMAPPABLE;
      else if (n > 0 && $signed(t) <= $signed(trk.last_host)) trk.map_fault = ST_HOST_NOT_INC;
    end
    if (n == 0) trk.first_host = t;
    if ($signed(t) <= $signed(win_lo)) begin
      trk.lo_idx  = n;
      trk.lo_time = t;
    end
    if (!trk.hi_seen && $signed(win_hi) <= $signed(t)) begin
      trk.hi_idx  = n;
      trk.hi_time = t;
      trk.hi_seen = 1'b1;
    end
    if (!trk.mid_seen && $signed(strike_w) <= $signed(t)) begin
      trk.mid_seen = 1'b1;
      dist_lo = strike_w - trk.last_host;
      dist_hi = t - strike_w;
      // tie goes to the earlier frame
      if (n > 0 && dist_lo <= dist_hi) begin
        trk.mid_idx  = n - 1;
        trk.mid_time = trk.last_host;
      end else begin
        trk.mid_idx  = n;
        trk.mid_time = t;
      end
    end
    trk.last_id   = id;
    trk.last_dev  = dev;
    trk.last_host = t;
    trk.count     = n + 1;
  endfunction

  function automatic window_t close_list();
    word_t       win_lo, win_hi, near_t;
    int unsigned near_i;
    bit          short_pre, short_post;
    status_e     st;
    window_t     w;
    win_lo = strike_w - pre_w;
    win_hi = strike_w + post_w;
    if (pre_w[TIME_W-1] || post_w[TIME_W-1]) st = ST_BAD_WINDOW;
    else if (!mapper_on) st = ST_NO_MAPPER;
    else if (trk.count == 0) st = ST_NO_FRAMES;
    else if (trk.spilled) st = ST_TOO_MANY;
    else if (trk.seq_fault != ST_OK) st = trk.seq_fault;
    else if (trk.map_fault != ST_OK) st = trk.map_fault;
    else begin
      short_pre  = $signed(win_lo) < $signed(trk.first_host);
      short_post = $signed(trk.last_host) < $signed(win_hi);
      if (short_pre && short_post) st = ST_BOTH_SHORT;
      else if (short_pre) st = ST_PRE_SHORT;
      else if (short_post) st = ST_POST_SHORT;
      else st = ST_OK;
    end
    w = blank_window(st);
    if (st == ST_OK) begin
      if (trk.mid_seen) begin
        near_i = trk.mid_idx;
        near_t = trk.mid_time;
      end else begin
        near_i = trk.count - 1;
        near_t = trk.last_host;
      end
      w.idx[0] = END_W'(trk.lo_idx[BEGIN_W-1:0]);
      w.idx[1] = END_W'(trk.hi_idx + 1);
      w.idx[2] = END_W'(near_i[NEAR_W-1:0]);
      w.tm[0]  = near_t;
      w.tm[1]  = near_t - strike_w;
      w.tm[2]  = win_lo;
      w.tm[3]  = win_hi;
      w.tm[4]  = trk.lo_time;
      w.tm[5]  = trk.hi_time;
      w.tm[6]  = strike_w - trk.lo_time;
      w.tm[7]  = trk.hi_time - strike_w;
    end
    clear_list();
    return w;
  endfunction

  function automatic row_t cfg_row(word_t s, word_t p, word_t q, logic m);
    row_t r;
    r.op    = ROW_CFG;
    r.a     = s;
    r.b     = p;
    r.c     = q;
    r.flag  = m;
    r.typed = 1'b0;
    r.want  = ST_OK;
    return r;
  endfunction

  function automatic row_t frame_row(word_t id, word_t dev, word_t t, logic ok);
    row_t r;
    r.op    = ROW_FRAME;
    r.a     = id;
    r.b     = dev;
    r.c     = t;
    r.flag  = ok;
    r.typed = 1'b0;
    r.want  = ST_OK;
    return r;
  endfunction

  function automatic row_t end_row(bit typed, status_e want);
    row_t r;
    r.op    = ROW_END;
    r.a     = '0;
    r.b     = '0;
    r.c     = '0;
    r.flag  = 1'b0;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic offer(logic kind, word_t id, word_t dev, word_t t, logic ok, bit typed,
                       status_e want);
    window_t w;
    while (!no_idle && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.seq_num      <= id;
    in_ch.dev_time     <= dev;
    in_ch.mapped_time  <= t;
    in_ch.mapped_valid <= ok;
    do @(posedge clk_i); while (!in_ch.ready);
    if (kind == KIND_FRAME) log_frame(id, dev, t, ok);
    else begin
      w = close_list();
      pending_windows.insert(pending_windows.size(), typed ? blank_window(want) : w);
    end
  endtask

  // bit 4 of which writes an unused index, which the block ignores
  task automatic program_window(word_t s, word_t p, word_t q, word_t m,
                                logic [CFG_IDX_W-1:0] spare, logic [4:0] which);
    logic [CFG_IDX_W-1:0] idxs [5];
    word_t                vals [5];
    idxs = '{CFG_STRIKE, CFG_PRE_ROLL, CFG_POST_ROLL, CFG_MAPPER_READY, spare};
    vals = '{s, p, q, m, rand64()};
    for (int i = 0; i < 5; i++) begin
      if (which[i]) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idxs[i];
        cfg_ch.data  <= vals[i];
        do @(posedge clk_i); while (!cfg_ch.ready);
        case (idxs[i])
          CFG_STRIKE:       strike_w  = vals[i];
          CFG_PRE_ROLL:     pre_w     = vals[i];
          CFG_POST_ROLL:    post_w    = vals[i];
          CFG_MAPPER_READY: mapper_on = vals[i][0];
          default: ;
        endcase
      end
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for all results, then for frames still in the pipe
  task automatic settle_list();
    in_ch.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    window_t got, want;
    got.status = out_ch.status;
    got.idx[0] = END_W'(out_ch.start_index);
    got.idx[1] = out_ch.stop_index;
    got.idx[2] = END_W'(out_ch.strike_index);
    got.tm[0]  = out_ch.strike_frame_time;
    got.tm[1]  = out_ch.strike_time_error;
    got.tm[2]  = out_ch.want_start_time;
    got.tm[3]  = out_ch.want_stop_time;
    got.tm[4]  = out_ch.selected_start_time;
    got.tm[5]  = out_ch.chosen_stop_time;
    got.tm[6]  = out_ch.lead_time;
    got.tm[7]  = out_ch.trail_time;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_windows.size() == 0) begin
        $display("%0t: result with no end request pending, status %0d", $time, got.status);
        fails++;
      end else begin
        want = pending_windows.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          fails++;
        end
        for (int i = 0; i < 3; i++) begin
          if (got.idx[i] !== want.idx[i]) begin
            $display("%0t: %s expected %0d got %0d", $time, idx_name[i], want.idx[i],
                     got.idx[i]);
            fails++;
          end
        end
        for (int i = 0; i < 8; i++) begin
          if (got.tm[i] !== want.tm[i]) begin
            $display("%0t: %s expected %h got %h", $time, tm_name[i], want.tm[i], got.tm[i]);
            fails++;
          end
        end
      end
    end
    out_ch.ready <= no_idle || $urandom_range(0, 99) >= 10;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    row_t                 plan [$];
    int                   n, bad_at, r;
    int unsigned          dstep, tstep;
    fault_e               fault;
    bit                   noisy;
    word_t                id, dev, t, s, m;
    logic                 ok;
    logic [4:0]           which;
    logic [CFG_IDX_W-1:0] spare;

    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_FRAME;
    in_ch.seq_num      <= '0;
    in_ch.dev_time     <= '0;
    in_ch.mapped_time  <= '0;
    in_ch.mapped_valid <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_STRIKE;
    cfg_ch.data        <= '0;
    strike_w  = '0;
    pre_w     = '0;
    post_w    = '0;
    mapper_on = 1'b0;
    clear_list();
    spare = CFG_IDX_W'(CFG_MAPPER_READY + 1);

    // window 900..1100 around a strike at 1000
    plan.insert(plan.size(), end_row(1'b1, ST_NO_MAPPER));
    plan.insert(plan.size(), cfg_row(64'd1000, 64'd100, 64'd100, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_NO_FRAMES));
    plan.insert(plan.size(), frame_row(64'd5, 64'd10, 64'd880, 1'b1));
    plan.insert(plan.size(), frame_row(64'd6, 64'd20, 64'd990, 1'b1));
    plan.insert(plan.size(), frame_row(64'd7, 64'd30, 64'd1010, 1'b1));  // equal distance
    plan.insert(plan.size(), frame_row(64'd8, 64'd40, 64'd1100, 1'b1));
    plan.insert(plan.size(), end_row(1'b0, ST_OK));
    plan.insert(plan.size(), frame_row(64'd1, 64'd0, 64'd900, 1'b1));
    plan.insert(plan.size(), frame_row(64'd3, 64'd1, 64'd950, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_ID_GAP));
    plan.insert(plan.size(), frame_row(ALL_ONES, 64'd5, 64'd900, 1'b1));
    plan.insert(plan.size(), frame_row(64'd0, 64'd6, 64'd950, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_ID_NOT_INC));
    plan.insert(plan.size(), frame_row(64'd0, ALL_ONES, 64'd900, 1'b1));
    plan.insert(plan.size(), frame_row(64'd1, ALL_ONES, 64'd950, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_DEV_NOT_INC));
    plan.insert(plan.size(), frame_row(64'd7, 64'd1, 64'd900, 1'b0));
    plan.insert(plan.size(), end_row(1'b1, ST_UNMAPPABLE));
    plan.insert(plan.size(), frame_row(64'd1, 64'd1, TIME_MAX, 1'b1));
    plan.insert(plan.size(), frame_row(64'd2, 64'd2, SIGN_BIT, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_HOST_NOT_INC));
    plan.insert(plan.size(), frame_row(64'd1, 64'd1, 64'd1200, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_PRE_SHORT));
    plan.insert(plan.size(), frame_row(64'd1, 64'd1, 64'd800, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_POST_SHORT));
    plan.insert(plan.size(), frame_row(64'd1, 64'd1, 64'd1000, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_BOTH_SHORT));
    plan.insert(plan.size(), cfg_row(64'd1000, ALL_ONES, 64'd100, 1'b1));
    plan.insert(plan.size(), end_row(1'b1, ST_BAD_WINDOW));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].op)
        ROW_CFG: begin
          settle_list();
          program_window(plan[i].a, plan[i].b, plan[i].c, word_t'(plan[i].flag), spare,
                         5'b01111);
        end
        ROW_FRAME: offer(KIND_FRAME, plan[i].a, plan[i].b, plan[i].c, plan[i].flag, 1'b0,
                         ST_OK);
        default: offer(KIND_END, '0, '0, '0, 1'b0, plan[i].typed, plan[i].want);
      endcase
    end

    // full list with the strike on the last frame, then one to three frames past capacity
    for (int pass = 0; pass < 2; pass++) begin
      settle_list();
      no_idle = (pass == 0);
      program_window(word_t'(10 * (MAX_FRAMES - 1)), '0, '0, 64'd1, spare, 5'b01111);
      n = (pass == 0) ? MAX_FRAMES : MAX_FRAMES + $urandom_range(1, 3);
      for (int k = 0; k < n; k++)
        offer(KIND_FRAME, word_t'(k), word_t'(k), word_t'(10 * k), 1'b1, 1'b0, ST_OK);
      offer(KIND_END, rand64(), rand64(), rand64(), 1'b1, 1'b0, ST_OK);
    end

    while (rand_sent < 1000) begin
      settle_list();
      no_idle = (rand_sent >= 400 && rand_sent < 600);
      r = $urandom_range(0, 99);
      s = (r < 8) ? TIME_MAX : (r < 16) ? SIGN_BIT : (r < 50) ? rand64() :
          word_t'($urandom_range(0, 100000));
      m = rand64();
      m[0] = ($urandom_range(0, 99) < 95);
      which[3:0] = 4'($urandom_range(1, 15));
      which[4] = ($urandom_range(0, 99) < 10);
      spare = CFG_IDX_W'($urandom_range(CFG_MAPPER_READY + 1, 255));
      program_window(s, pick_roll(), pick_roll(), m, spare, which);

      n      = $urandom_range(0, 12);
      noisy  = ($urandom_range(0, 99) < 10);
      bad_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 11) : -1;
      fault  = fault_e'($urandom_range(0, 4));
      id     = rand64();
      dev    = rand64();
      dstep  = $urandom_range(1, 1000);
      tstep  = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 5000);
      t      = strike_w - word_t'($urandom_range(0, (n + 1) * tstep));
      for (int k = 0; k < n; k++) begin
        if (noisy) begin
          id  = rand64();
          dev = rand64();
          t   = rand64();
          ok  = $urandom_range(0, 1);
        end else begin
          ok = 1'b1;
          if (k == bad_at) begin
            case (fault)
              FLT_ID_BACK:  id  -= $urandom_range(1, 3);
              FLT_ID_GAP:   id  += $urandom_range(1, 1000);
              FLT_DEV_BACK: dev -= dstep + $urandom_range(0, 3);
              FLT_UNMAPPED: ok  = 1'b0;
              default:      t   -= tstep + $urandom_range(0, 3);
            endcase
          end
        end
        offer(KIND_FRAME, id, dev, t, ok, 1'b0, ST_OK);
        id  += 1;
        dev += dstep;
        t   += tstep;
      end
      offer(KIND_END, rand64(), rand64(), rand64(), $urandom_range(0, 1), 1'b0, ST_OK);
      rand_sent += n + 1;
    end

    settle_list();
    repeat (6) @(posedge clk_i);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
